/* hw/rtl/cdpf_pkg.sv */
// Package with shared constants and types for the contour distance peak finder.
`timescale 1ns / 1ps

package cdpf_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int MAX_PEAKS_DEF  = 6;

  localparam int CENTER_W    = 12;
  localparam int FRAME_H_W   = 13;
  localparam int OUT_XY_W    = 12;
  localparam int DIST_OUT_W  = 25;
  localparam int COUNT_OUT_W = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;

  localparam int BOTTOM_MARGIN = 10;

  localparam logic [FRAME_H_W-1:0] FRAME_H_RESET = 13'd480;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

  typedef struct packed {
    logic [CENTER_W-1:0]  center_x;
    logic [CENTER_W-1:0]  center_y;
    logic [FRAME_H_W-1:0] frame_height;
  } cdpf_cfg_t;

  typedef struct packed {
    logic valid;
    logic first;
  } cdpf_ctrl_t;

endpackage

/* hw/rtl/cdpf_ifs.sv */
// Channel interfaces for points, peak results and register writes.
`timescale 1ns / 1ps

interface cdpf_in_if #(
  parameter int COORD_BITS = cdpf_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] point_x;
  logic [COORD_BITS-1:0] point_y;
  logic                  first_point;

  modport source (output valid, output point_x, output point_y, output first_point,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input first_point,
                output ready);
endinterface

interface cdpf_out_if;
  import cdpf_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   peak_found;
  logic [OUT_XY_W-1:0]    peak_x;
  logic [OUT_XY_W-1:0]    peak_y;
  logic [DIST_OUT_W-1:0]  peak_distance;
  logic [COUNT_OUT_W-1:0] peak_count;

  modport source (output valid, output peak_found, output peak_x, output peak_y,
                  output peak_distance, output peak_count, input ready);
  modport sink (input valid, input peak_found, input peak_x, input peak_y,
                input peak_distance, input peak_count, output ready);
endinterface

interface cdpf_cfg_if;
  import cdpf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/cdpf_dist.sv */
// Distance stage: absolute differences to the center and registered squares.
`timescale 1ns / 1ps

module cdpf_dist #(
  parameter int COORD_BITS = cdpf_pkg::COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      advance,
  input  logic                      in_valid,
  input  logic [COORD_BITS-1:0]     in_x,
  input  logic [COORD_BITS-1:0]     in_y,
  input  logic                      in_first,
  input  cdpf_pkg::cdpf_cfg_t       cfg,
  output cdpf_pkg::cdpf_ctrl_t      s1_ctrl,
  output logic [COORD_BITS-1:0]     s1_x,
  output logic [COORD_BITS-1:0]     s1_y,
  output logic [2*COORD_BITS-1:0]   s1_sqx,
  output logic [2*COORD_BITS-1:0]   s1_sqy
);
  import cdpf_pkg::*;

  logic [COORD_BITS-1:0]   cx;
  logic [COORD_BITS-1:0]   cy;
  logic [COORD_BITS-1:0]   dx;
  logic [COORD_BITS-1:0]   dy;
  cdpf_ctrl_t              ctrl_r;
  logic [COORD_BITS-1:0]   x_r;
  logic [COORD_BITS-1:0]   y_r;
  logic [2*COORD_BITS-1:0] sqx_r;
  logic [2*COORD_BITS-1:0] sqy_r;

  assign cx = COORD_BITS'(cfg.center_x);
  assign cy = COORD_BITS'(cfg.center_y);
  assign dx = (in_x >= cx) ? (in_x - cx) : (cx - in_x);
  assign dy = (in_y >= cy) ? (in_y - cy) : (cy - in_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else if (advance) begin
      ctrl_r.valid <= in_valid;
      ctrl_r.first <= in_first;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      x_r   <= in_x;
      y_r   <= in_y;
      sqx_r <= dx * dx;
      sqy_r <= dy * dy;
    end
  end

  assign s1_ctrl = ctrl_r;
  assign s1_x    = x_r;
  assign s1_y    = y_r;
  assign s1_sqx  = sqx_r;
  assign s1_sqy  = sqy_r;

endmodule

/* hw/rtl/cdpf_peak.sv */
// Peak stage: local maximum test, running contour state and result register.
`timescale 1ns / 1ps

module cdpf_peak #(
  parameter int COORD_BITS = cdpf_pkg::COORD_BITS_DEF,
  parameter int MAX_PEAKS  = cdpf_pkg::MAX_PEAKS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 advance,
  input  cdpf_pkg::cdpf_ctrl_t                 s1_ctrl,
  input  logic [COORD_BITS-1:0]                s1_x,
  input  logic [COORD_BITS-1:0]                s1_y,
  input  logic [2*COORD_BITS-1:0]              s1_sqx,
  input  logic [2*COORD_BITS-1:0]              s1_sqy,
  input  cdpf_pkg::cdpf_cfg_t                  cfg,
  output logic                                 out_valid,
  output logic                                 out_found,
  output logic [cdpf_pkg::OUT_XY_W-1:0]        out_x,
  output logic [cdpf_pkg::OUT_XY_W-1:0]        out_y,
  output logic [cdpf_pkg::DIST_OUT_W-1:0]      out_distance,
  output logic [cdpf_pkg::COUNT_OUT_W-1:0]     out_count
);
  import cdpf_pkg::*;

  localparam int DW    = 2 * COORD_BITS + 1;
  localparam int CNT_W = $clog2(MAX_PEAKS + 1);
  localparam int YW    = ((COORD_BITS > FRAME_H_W) ? COORD_BITS : FRAME_H_W) + 1;

  logic [DW-1:0]          last_r;
  logic [DW-1:0]          older_r;
  logic [COORD_BITS-1:0]  prev_x_r;
  logic [COORD_BITS-1:0]  prev_y_r;
  logic [CNT_W-1:0]       cnt_r;

  logic [DW-1:0]          last_e;
  logic [DW-1:0]          older_e;
  logic [COORD_BITS-1:0]  prev_x_e;
  logic [COORD_BITS-1:0]  prev_y_e;
  logic [CNT_W-1:0]       cnt_e;
  logic [DW-1:0]          cur_dist;
  logic                   active;
  logic                   margin_ok;
  logic                   peak;
  logic [CNT_W-1:0]       cnt_nxt;
  logic                   step;

  logic                   valid_r;
  logic                   found_r;
  logic [OUT_XY_W-1:0]    x_r;
  logic [OUT_XY_W-1:0]    y_r;
  logic [DIST_OUT_W-1:0]  dist_r;
  logic [COUNT_OUT_W-1:0] count_r;

  // A first point sees the running state as cleared.
  assign last_e   = s1_ctrl.first ? '0 : last_r;
  assign older_e  = s1_ctrl.first ? '0 : older_r;
  assign prev_x_e = s1_ctrl.first ? '0 : prev_x_r;
  assign prev_y_e = s1_ctrl.first ? '0 : prev_y_r;
  assign cnt_e    = s1_ctrl.first ? '0 : cnt_r;

  assign cur_dist  = DW'(s1_sqx) + DW'(s1_sqy);
  assign active    = (cnt_e < CNT_W'(MAX_PEAKS));
  assign margin_ok = ((YW'(prev_y_e) + YW'(BOTTOM_MARGIN)) < YW'(cfg.frame_height));
  assign peak      = active && (cur_dist < last_e) && (last_e > older_e) &&
                     (prev_x_e != '0) && margin_ok;
  assign cnt_nxt   = cnt_e + CNT_W'(peak);
  assign step      = advance && s1_ctrl.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r   <= '0;
      older_r  <= '0;
      prev_x_r <= '0;
      prev_y_r <= '0;
      cnt_r    <= '0;
    end else if (step) begin
      last_r   <= active ? cur_dist : last_e;
      older_r  <= active ? last_e : older_e;
      prev_x_r <= active ? s1_x : prev_x_e;
      prev_y_r <= active ? s1_y : prev_y_e;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= s1_ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      found_r <= peak;
      x_r     <= peak ? OUT_XY_W'(prev_x_e) : '0;
      y_r     <= peak ? OUT_XY_W'(prev_y_e) : '0;
      dist_r  <= peak ? DIST_OUT_W'(cur_dist) : '0;
      count_r <= COUNT_OUT_W'(cnt_nxt);
    end
  end

  assign out_valid    = valid_r;
  assign out_found    = found_r;
  assign out_x        = x_r;
  assign out_y        = y_r;
  assign out_distance = dist_r;
  assign out_count    = count_r;

`ifndef SYNTHESIS
  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_PEAKS))
    else $error("peak count exceeds the limit");

  a_peak_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (step && peak) |=> (cnt_r == $past(cnt_e) + 1'b1))
    else $error("a found peak did not advance the count");

  a_limit_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !s1_ctrl.first && (cnt_r == CNT_W'(MAX_PEAKS))) |=>
      ($stable(last_r) && $stable(prev_x_r) && $stable(cnt_r)))
    else $error("state moved after the peak limit was reached");

  a_no_peak_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !found_r) |-> (x_r == '0 && y_r == '0 && dist_r == '0))
    else $error("result without a peak carries nonzero payload");
`endif

endmodule

/* hw/rtl/contour_distance_peak_finder_unit.sv */
// Top level of the contour distance peak finder with its register file.
//
//   channel  direction  transaction
//   in_ch    sink       one contour point (x, y, first point flag)
//   out_ch   source     one peak result per point
//   cfg_ch   sink       one register write (index, data)
//
// A point passes from acceptance to its result through the register for the squares of the
// distance, then through the peak test and the running state update in the result register.
// One point is accepted every cycle while the result side takes results.
// When out_ch stalls with a result held, the whole pipe holds and in_ch.ready drops.
// Reset clears the registers to center 0, 0 and frame height 480 and empties the pipe.
// Register writes are taken in every cycle.
`timescale 1ns / 1ps

module contour_distance_peak_finder_unit #(
  parameter int COORD_BITS = cdpf_pkg::COORD_BITS_DEF,
  parameter int MAX_PEAKS  = cdpf_pkg::MAX_PEAKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  cdpf_in_if.sink     in_ch,
  cdpf_out_if.source  out_ch,
  cdpf_cfg_if.sink    cfg_ch
);
  import cdpf_pkg::*;

  logic [CENTER_W-1:0]     center_x_r;
  logic [CENTER_W-1:0]     center_y_r;
  logic [FRAME_H_W-1:0]    frame_height_r;
  cdpf_cfg_t               cfg;
  logic                    advance;
  cdpf_ctrl_t              s1_ctrl;
  logic [COORD_BITS-1:0]   s1_x;
  logic [COORD_BITS-1:0]   s1_y;
  logic [2*COORD_BITS-1:0] s1_sqx;
  logic [2*COORD_BITS-1:0] s1_sqy;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r     <= '0;
      center_y_r     <= '0;
      frame_height_r <= FRAME_H_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_CENTER_X:     center_x_r     <= cfg_ch.data[CENTER_W-1:0];
        CFG_CENTER_Y:     center_y_r     <= cfg_ch.data[CENTER_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_ch.data[FRAME_H_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.center_x     = center_x_r;
  assign cfg.center_y     = center_y_r;
  assign cfg.frame_height = frame_height_r;

  assign advance     = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = advance;

  cdpf_dist #(
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .in_valid (in_ch.valid),
    .in_x     (in_ch.point_x),
    .in_y     (in_ch.point_y),
    .in_first (in_ch.first_point),
    .cfg      (cfg),
    .s1_ctrl  (s1_ctrl),
    .s1_x     (s1_x),
    .s1_y     (s1_y),
    .s1_sqx   (s1_sqx),
    .s1_sqy   (s1_sqy)
  );

  cdpf_peak #(
    .COORD_BITS (COORD_BITS),
    .MAX_PEAKS  (MAX_PEAKS)
  ) u_peak (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (advance),
    .s1_ctrl      (s1_ctrl),
    .s1_x         (s1_x),
    .s1_y         (s1_y),
    .s1_sqx       (s1_sqx),
    .s1_sqy       (s1_sqy),
    .cfg          (cfg),
    .out_valid    (out_ch.valid),
    .out_found    (out_ch.peak_found),
    .out_x        (out_ch.peak_x),
    .out_y        (out_ch.peak_y),
    .out_distance (out_ch.peak_distance),
    .out_count    (out_ch.peak_count)
  );

endmodule
